@@ rtl/mcs_pkg.sv @@
// Shared types, codes and defaults of the masked configuration space register file.
package mcs_pkg;

  localparam int SPACE_BYTES_DEF = 256;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_WARM  = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  localparam logic [1:0] TBL_IMAGE = 2'd0;
  localparam logic [1:0] TBL_WMASK = 2'd1;
  localparam logic [1:0] TBL_CMASK = 2'd2;
  localparam logic [1:0] TBL_KMASK = 2'd3;

  localparam logic [1:0] CFG_FIRST_BASE  = 2'd0;
  localparam logic [1:0] CFG_SECOND_BASE = 2'd1;
  localparam logic [1:0] CFG_SPAN        = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic [1:0]  table_select;
    logic [7:0]  table_byte;
  } item_t;

  typedef struct packed {
    logic capture;
    logic cnt_clr;
    logic cnt_inc;
    logic issue_byte;
    logic issue_part;
    logic issue_sweep;
    logic gather;
    logic wr_byte;
    logic wr_part;
    logic wr_warm;
    logic wr_clear;
    logic wr_table;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       bad;
    logic       last_byte;
    logic       last_entry;
    logic       part_go;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/mcs_req_if.sv @@
// Request channel of the masked configuration space register file.
interface mcs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  offset;
  logic [2:0]  access_size;
  logic [31:0] write_data;
  logic [1:0]  table_select;
  logic [7:0]  table_byte;

  modport source (
    output valid, func, offset, access_size, write_data, table_select, table_byte,
    input  ready
  );
  modport sink (
    input  valid, func, offset, access_size, write_data, table_select, table_byte,
    output ready
  );
endinterface

@@ rtl/mcs_rsp_if.sv @@
// Response channel of the masked configuration space register file.
interface mcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_error;

  modport source (
    output valid, read_data, access_error,
    input  ready
  );
  modport sink (
    input  valid, read_data, access_error,
    output ready
  );
endinterface

@@ rtl/mcs_ctrl.sv @@
// Sequencer that steps each request through the byte and sweep phases of the datapath.
module mcs_ctrl import mcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_EXEC   = 4'd2;
  localparam logic [3:0] ST_RISSUE = 4'd3;
  localparam logic [3:0] ST_RCAP   = 4'd4;
  localparam logic [3:0] ST_WISSUE = 4'd5;
  localparam logic [3:0] ST_WMOD   = 4'd6;
  localparam logic [3:0] ST_PISSUE = 4'd7;
  localparam logic [3:0] ST_PMOD   = 4'd8;
  localparam logic [3:0] ST_GISSUE = 4'd9;
  localparam logic [3:0] ST_GMOD   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        if (sts_i.last_entry) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.func)
          FUNC_READ:  state_d = sts_i.bad ? ST_DONE : ST_RISSUE;
          FUNC_WRITE: state_d = sts_i.bad ? ST_DONE : ST_WISSUE;
          FUNC_WARM:  state_d = ST_GISSUE;
          FUNC_LOAD: begin
            cmd_o.wr_table = 1'b1;
            state_d        = ST_DONE;
          end
          default:    state_d = ST_DONE;
        endcase
      end
      ST_RISSUE: begin
        cmd_o.issue_byte = 1'b1;
        state_d          = ST_RCAP;
      end
      ST_RCAP: begin
        cmd_o.gather = 1'b1;
        if (sts_i.last_byte) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_RISSUE;
        end
      end
      ST_WISSUE: begin
        cmd_o.issue_byte = 1'b1;
        state_d          = ST_WMOD;
      end
      ST_WMOD: begin
        cmd_o.wr_byte = 1'b1;
        if (sts_i.part_go) begin
          state_d = ST_PISSUE;
        end else if (sts_i.last_byte) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_WISSUE;
        end
      end
      ST_PISSUE: begin
        cmd_o.issue_part = 1'b1;
        state_d          = ST_PMOD;
      end
      ST_PMOD: begin
        cmd_o.wr_part = 1'b1;
        if (sts_i.last_byte) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_WISSUE;
        end
      end
      ST_GISSUE: begin
        cmd_o.issue_sweep = 1'b1;
        state_d           = ST_GMOD;
      end
      ST_GMOD: begin
        cmd_o.wr_warm = 1'b1;
        if (sts_i.last_entry) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = ST_GISSUE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

@@ rtl/mcs_dpath.sv @@
// Datapath with the register and table memories, byte merge, partner clear and response register.
module mcs_dpath import mcs_pkg::*; #(
  parameter int SpaceBytes = SPACE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  item_t       item_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        rsp_ready_i,
  output logic        rsp_valid_o,
  output logic [31:0] rsp_read_data_o,
  output logic        rsp_access_error_o
);

  localparam int AW = $clog2(SpaceBytes);
  localparam int SW = ($clog2(SpaceBytes + 1) > 9) ? $clog2(SpaceBytes + 1) : 9;
  localparam int RedSteps = 5;

  logic [7:0] reg_mem [SpaceBytes];
  logic [7:0] img_mem [SpaceBytes];
  logic [7:0] wm_mem  [SpaceBytes];
  logic [7:0] cm_mem  [SpaceBytes];
  logic [7:0] km_mem  [SpaceBytes];

  logic [7:0]    first_q, second_q;
  logic [3:0]    span_q;
  item_t         item_q;
  logic [AW-1:0] cnt_q;
  logic [31:0]   acc_q;
  logic [AW-1:0] part_addr_q;
  logic [7:0]    part_clr_q;
  logic [7:0]    rd_reg_q, rd_img_q, rd_wm_q, rd_cm_q, rd_km_q;
  logic          out_valid_q;
  logic [31:0]   rdata_q;
  logic          err_q;

  logic          size_ok, bad, off_oob;
  logic [SW-1:0] idx, off_w;
  logic [AW-1:0] idx_a, off_a, rd_addr;
  logic          rd_en;
  logic [1:0]    lane;
  logic [7:0]    wbyte, clr, merged;
  logic          hit_a, hit_b;
  logic [SW-1:0] dif;
  logic [7:0]    base;
  logic [8:0]    pv;
  logic [SW-1:0] pw;
  logic [AW-1:0] part_addr;
  logic          reg_we;
  logic [AW-1:0] reg_wa, tbl_wa;
  logic [7:0]    reg_wd, tbl_wd;
  logic          tbl_we;
  logic [31:0]   ones;
  logic [31:0]   rdata_d;
  logic          err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      span_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_BASE:  first_q  <= cfg_wdata_i;
        CFG_SECOND_BASE: second_q <= cfg_wdata_i;
        CFG_SPAN:        span_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  assign off_w   = SW'(item_q.offset);
  assign size_ok = (item_q.access_size == 3'd1) || (item_q.access_size == 3'd2) ||
                   (item_q.access_size == 3'd4);
  assign bad     = !size_ok || ((off_w + SW'(item_q.access_size)) > SW'(SpaceBytes));
  assign off_oob = off_w >= SW'(SpaceBytes);
  assign idx     = off_w + SW'(cnt_q);
  assign idx_a   = idx[AW-1:0];
  assign off_a   = off_w[AW-1:0];
  assign lane    = cnt_q[1:0];
  assign wbyte   = item_q.write_data[8*lane +: 8];
  assign clr     = wbyte & rd_cm_q;
  assign merged  = ((rd_reg_q & ~rd_wm_q) | (wbyte & rd_wm_q)) & ~clr;

  // Partner byte of a coupled clear, wrapped into the space by conditional subtraction.
  always_comb begin
    hit_a = (idx >= SW'(first_q)) && (idx < (SW'(first_q) + SW'(span_q)));
    hit_b = (idx >= SW'(second_q)) && (idx < (SW'(second_q) + SW'(span_q)));
    dif   = hit_a ? (idx - SW'(first_q)) : (idx - SW'(second_q));
    base  = hit_a ? second_q : first_q;
    pv    = 9'(base) + dif[8:0];
    for (int k = RedSteps - 1; k >= 0; k--) begin
      if (32'(pv) >= (32'(SpaceBytes) << k)) begin
        pv = pv - 9'(32'(SpaceBytes) << k);
      end
    end
    pw        = SW'(pv);
    part_addr = pw[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      part_addr_q <= part_addr;
      part_clr_q  <= clr;
    end
  end

  always_comb begin
    rd_en   = cmd_i.issue_byte || cmd_i.issue_part || cmd_i.issue_sweep;
    rd_addr = idx_a;
    if (cmd_i.issue_part) begin
      rd_addr = part_addr_q;
    end else if (cmd_i.issue_sweep) begin
      rd_addr = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_reg_q <= reg_mem[rd_addr];
      rd_img_q <= img_mem[rd_addr];
      rd_wm_q  <= wm_mem[rd_addr];
      rd_cm_q  <= cm_mem[rd_addr];
      rd_km_q  <= km_mem[rd_addr];
    end
  end

  always_comb begin
    reg_we = 1'b1;
    reg_wa = cnt_q;
    reg_wd = '0;
    if (cmd_i.wr_byte) begin
      reg_wa = idx_a;
      reg_wd = merged;
    end else if (cmd_i.wr_part) begin
      reg_wa = part_addr_q;
      reg_wd = rd_reg_q & ~part_clr_q;
    end else if (cmd_i.wr_warm) begin
      reg_wd = (rd_reg_q & rd_km_q) | (rd_img_q & ~rd_km_q);
    end else if (!cmd_i.wr_clear) begin
      reg_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      reg_mem[reg_wa] <= reg_wd;
    end
  end

  assign tbl_we = cmd_i.wr_clear || (cmd_i.wr_table && !off_oob);
  assign tbl_wa = cmd_i.wr_clear ? cnt_q : off_a;
  assign tbl_wd = cmd_i.wr_clear ? 8'h00 : item_q.table_byte;

  always_ff @(posedge clk_i) begin
    if (tbl_we && (cmd_i.wr_clear || item_q.table_select == TBL_IMAGE)) begin
      img_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_we && (cmd_i.wr_clear || item_q.table_select == TBL_WMASK)) begin
      wm_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_we && (cmd_i.wr_clear || item_q.table_select == TBL_CMASK)) begin
      cm_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_we && (cmd_i.wr_clear || item_q.table_select == TBL_KMASK)) begin
      km_mem[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (cmd_i.gather) begin
      acc_q[8*lane +: 8] <= rd_reg_q;
    end
  end

  always_comb begin
    case (item_q.access_size)
      3'd0:    ones = 32'h0000_0000;
      3'd1:    ones = 32'h0000_00FF;
      3'd2:    ones = 32'h0000_FFFF;
      3'd3:    ones = 32'h00FF_FFFF;
      default: ones = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    rdata_d = '0;
    err_d   = 1'b0;
    case (item_q.func)
      FUNC_READ: begin
        rdata_d = bad ? ones : acc_q;
        err_d   = bad;
      end
      FUNC_WRITE: err_d = bad;
      FUNC_LOAD:  err_d = off_oob;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rdata_q <= rdata_d;
      err_q   <= err_d;
    end
  end

  assign rsp_valid_o        = out_valid_q;
  assign rsp_read_data_o    = rdata_q;
  assign rsp_access_error_o = err_q;

  assign sts_o.func       = item_q.func;
  assign sts_o.bad        = bad;
  assign sts_o.last_byte  = cnt_q == (AW'(item_q.access_size) - AW'(1));
  assign sts_o.last_entry = cnt_q == AW'(SpaceBytes - 1);
  assign sts_o.part_go    = (hit_a || hit_b) && (clr != 8'h00);
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

endmodule

@@ rtl/masked_config_space_register_file.sv @@
// Top level of the masked configuration space register file.
//
//   port        | dir | content
//   ------------+-----+-----------------------------------------------------------
//   req_i       | in  | func, offset, access_size, write_data, table_select, table_byte
//   rsp_o       | out | read_data, access_error, one response per request
//   cfg_*_i     | in  | coupled first base, second base and span, write only
//
// One request is in flight at a time. A table load or a rejected access is answered
// without reading the register memory, a read takes a memory read and a capture per
// byte, and a write a read and a merged write per byte, plus a partner read and clear
// for every byte whose cleared bits reach a coupled partner. A warm reset walks the
// whole space; every byte costs a read and a write of the register memory. After reset
// a clearing pass zeroes all memories before the first request is taken. A finished
// response waits in the output register while the next request is accepted.
module masked_config_space_register_file import mcs_pkg::*; #(
  parameter int SpaceBytes = SPACE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  mcs_req_if.sink    req_i,
  mcs_rsp_if.source  rsp_o
);

  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  logic  req_ready;

  assign item.func         = req_i.func;
  assign item.offset       = req_i.offset;
  assign item.access_size  = req_i.access_size;
  assign item.write_data   = req_i.write_data;
  assign item.table_select = req_i.table_select;
  assign item.table_byte   = req_i.table_byte;
  assign req_i.ready       = req_ready;

  mcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcs_dpath #(
    .SpaceBytes (SpaceBytes)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .item_i             (item),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .rsp_read_data_o    (rsp_o.read_data),
    .rsp_access_error_o (rsp_o.access_error)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_ready) |=> !req_ready)
    else $error("request accepted while another is in progress");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> rsp_o.valid)
    else $error("finished request did not reach the response register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!rsp_o.valid || rsp_o.ready))
    else $error("pending response overwritten");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_byte, cmd.wr_part, cmd.wr_warm, cmd.wr_clear}))
    else $error("register memory write port driven by two sources");

endmodule

@@ test/masked_config_space_register_file_test.sv @@
// Self-checking test of the masked configuration space register file against an internal mirror.
module masked_config_space_register_file_test;
  import mcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPACE = SPACE_BYTES_DEF;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 244;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
  } reply_t;

  typedef struct packed {
    item_t  req;
    logic   typed;
    reply_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  mcs_req_if req_if ();
  mcs_rsp_if rsp_if ();

  masked_config_space_register_file #(
    .SpaceBytes(SPACE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [7:0] space_mirror [SPACE] = '{default: 8'h00};
  logic [7:0] image_mirror [SPACE] = '{default: 8'h00};
  logic [7:0] wmask_mirror [SPACE] = '{default: 8'h00};
  logic [7:0] cmask_mirror [SPACE] = '{default: 8'h00};
  logic [7:0] keep_mirror  [SPACE] = '{default: 8'h00};
  int unsigned c_first  = 0;
  int unsigned c_second = 0;
  int unsigned c_span   = 0;

  reply_t    awaited_replies [$];
  stim_row_t opening_rows [$];

  int  mismatches     = 0;
  int  replies_seen   = 0;
  int  n_reads        = 0;
  int  n_writes       = 0;
  int  n_warm         = 0;
  int  n_loads        = 0;
  int  n_errors       = 0;
  int  idle_cycles    = 0;
  int  sink_hold      = 0;
  bit  burst_mode     = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the mirror and returns the response it must produce.
  function automatic reply_t space_access_reply(input item_t r);
    reply_t      rep;
    int unsigned off, size, idx, partner, i;
    bit          bad;
    logic [7:0]  b, wm, clr;
    rep = '0;
    off = r.offset;
    size = r.access_size;
    bad = !(size == 1 || size == 2 || size == 4) || (off + size > SPACE);
    case (r.func)
      FUNC_READ: begin
        if (bad) begin
          rep.access_error = 1'b1;
          rep.read_data = (size >= 4) ? 32'hFFFF_FFFF : (32'd1 << (size * 8)) - 32'd1;
        end else begin
          for (i = 0; i < size; i++) rep.read_data[i*8 +: 8] = space_mirror[off + i];
        end
      end
      FUNC_WRITE: begin
        if (bad) begin
          rep.access_error = 1'b1;
        end else begin
          for (i = 0; i < size; i++) begin
            idx = off + i;
            b = r.write_data[i*8 +: 8];
            wm = wmask_mirror[idx];
            clr = b & cmask_mirror[idx];
            space_mirror[idx] = ((space_mirror[idx] & ~wm) | (b & wm)) & ~clr;
            if (idx >= c_first && idx < c_first + c_span) begin
              partner = (c_second + idx - c_first) % SPACE;
            end else if (idx >= c_second && idx < c_second + c_span) begin
              partner = (c_first + idx - c_second) % SPACE;
            end else begin
              partner = SPACE;
            end
            if (partner < SPACE) space_mirror[partner] = space_mirror[partner] & ~clr;
          end
        end
      end
      FUNC_WARM: begin
        for (i = 0; i < SPACE; i++) begin
          space_mirror[i] = (space_mirror[i] & keep_mirror[i]) |
                            (image_mirror[i] & ~keep_mirror[i]);
        end
      end
      default: begin
        case (r.table_select)
          TBL_IMAGE: image_mirror[off] = r.table_byte;
          TBL_WMASK: wmask_mirror[off] = r.table_byte;
          TBL_CMASK: cmask_mirror[off] = r.table_byte;
          default:   keep_mirror[off]  = r.table_byte;
        endcase
      end
    endcase
    return rep;
  endfunction

  function automatic stim_row_t opening_row(input logic [1:0] f, input logic [7:0] off,
                                            input logic [2:0] size, input logic [31:0] wd,
                                            input logic [1:0] sel, input logic [7:0] tb,
                                            input logic typed, input logic [31:0] rd,
                                            input logic er);
    stim_row_t row;
    row.req = '{func: f, offset: off, access_size: size, write_data: wd,
                table_select: sel, table_byte: tb};
    row.typed = typed;
    row.want = '{read_data: rd, access_error: er};
    return row;
  endfunction

  function automatic item_t random_request();
    item_t r;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.offset = 8'(c_first + $urandom_range(0, 13) + 253);
    else if (pick < 75) r.offset = 8'(c_second + $urandom_range(0, 13) + 253);
    else if (pick < 88) r.offset = 8'($urandom_range(244, 255));
    else r.offset = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      case ($urandom_range(0, 2))
        0: r.access_size = 3'd1;
        1: r.access_size = 3'd2;
        default: r.access_size = 3'd4;
      endcase
    end else begin
      r.access_size = 3'($urandom_range(0, 7));
    end
    r.write_data = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    r.table_select = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 25) r.table_byte = 8'hFF;
    else if (pick < 40) r.table_byte = 8'h00;
    else r.table_byte = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 4) r.func = FUNC_WARM;
    else if (pick < 30) r.func = FUNC_LOAD;
    else if (pick < 62) r.func = FUNC_WRITE;
    else r.func = FUNC_READ;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    end
  endtask

  task automatic issue_request(input item_t r, input logic typed, input reply_t typed_rep);
    int     gap;
    reply_t rep;
    gap = (burst_mode || $urandom_range(0, 2) != 0) ? 0 : gap_length();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= r.func;
    req_if.offset <= r.offset;
    req_if.access_size <= r.access_size;
    req_if.write_data <= r.write_data;
    req_if.table_select <= r.table_select;
    req_if.table_byte <= r.table_byte;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    rep = space_access_reply(r);
    awaited_replies.push_back(typed ? typed_rep : rep);
    case (r.func)
      FUNC_READ:  n_reads++;
      FUNC_WRITE: n_writes++;
      FUNC_WARM:  n_warm++;
      default:    n_loads++;
    endcase
    if (rep.access_error) n_errors++;
  endtask

  task automatic settle_replies(input int extra);
    req_if.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_coupling(input logic [7:0] first, input logic [7:0] second,
                              input logic [3:0] span);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FIRST_BASE;
    cfg_wdata_i <= first;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SECOND_BASE;
    cfg_wdata_i <= second;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SPAN;
    cfg_wdata_i <= {4'd0, span};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    c_first = first;
    c_second = second;
    c_span = span;
  endtask

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      rsp_if.ready <= 1'b0;
    end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
      sink_hold = gap_length() - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unrequested response", rsp_if.read_data, 32'd0);
      end else begin
        want = awaited_replies.pop_front();
        replies_seen++;
        if (rsp_if.read_data !== want.read_data) begin
          report_mismatch("read_data", rsp_if.read_data, want.read_data);
        end
        if (rsp_if.access_error !== want.access_error) begin
          report_mismatch("access_error", 32'(rsp_if.access_error), 32'(want.access_error));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no request or response moved for %0d cycles.", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] ph_first  [PHASES] = '{8'h10, 8'h00, 8'hFF, 8'h00, 8'h40, 8'hF8, 8'h80, 8'h00};
    logic [7:0] ph_second [PHASES] = '{8'h20, 8'h00, 8'h00, 8'hFF, 8'h44, 8'h04, 8'h80, 8'h00};
    logic [3:0] ph_span   [PHASES] = '{4'd4, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FIRST_BASE;
    cfg_wdata_i = 8'h00;
    req_if.valid = 1'b0;
    req_if.func = FUNC_READ;
    req_if.offset = 8'h00;
    req_if.access_size = 3'd0;
    req_if.write_data = 32'd0;
    req_if.table_select = TBL_IMAGE;
    req_if.table_byte = 8'h00;
    rsp_if.ready = 1'b0;

    opening_rows.push_back(opening_row(FUNC_READ, 8'd0, 3'd4, 0, TBL_IMAGE, 0, 1, 32'h0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd255, 3'd1, 0, TBL_IMAGE, 0, 1, 32'h0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd253, 3'd4, 0, TBL_IMAGE, 0, 1,
                                       32'hFFFF_FFFF, 1));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd0, 3'd0, 0, TBL_IMAGE, 0, 1, 32'h0, 1));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd8, 3'd3, 0, TBL_IMAGE, 0, 1,
                                       32'h00FF_FFFF, 1));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd8, 3'd7, 0, TBL_IMAGE, 0, 1,
                                       32'hFFFF_FFFF, 1));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd255, 3'd2, 0, TBL_IMAGE, 0, 1,
                                       32'h0000_FFFF, 1));
    opening_rows.push_back(opening_row(FUNC_WRITE, 8'd0, 3'd5, 32'hFFFF_FFFF, TBL_IMAGE, 0, 1,
                                       32'h0, 1));
    opening_rows.push_back(opening_row(FUNC_WRITE, 8'd254, 3'd4, 32'hFFFF_FFFF, TBL_IMAGE, 0,
                                       1, 32'h0, 1));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'd255, 3'd0, 0, TBL_IMAGE, 8'hA5, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'd0, 3'd0, 0, TBL_WMASK, 8'hFF, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'd1, 3'd0, 0, TBL_WMASK, 8'h0F, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'd1, 3'd0, 0, TBL_CMASK, 8'hF0, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'd0, 3'd0, 0, TBL_KMASK, 8'h3C, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_WRITE, 8'd0, 3'd2, 32'hFFFF_FFFF, TBL_IMAGE, 0, 0,
                                       0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd0, 3'd2, 0, TBL_IMAGE, 0, 0, 0, 0));
    opening_rows.push_back(opening_row(FUNC_WARM, 8'd0, 3'd0, 0, TBL_IMAGE, 0, 1, 32'h0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd0, 3'd4, 0, TBL_IMAGE, 0, 0, 0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'd252, 3'd4, 0, TBL_IMAGE, 0, 0, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'h22, 3'd0, 0, TBL_WMASK, 8'hFF, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_WRITE, 8'h22, 3'd1, 32'hFF, TBL_IMAGE, 0, 0, 0, 0));
    opening_rows.push_back(opening_row(FUNC_LOAD, 8'h12, 3'd0, 0, TBL_CMASK, 8'hFF, 1, 0, 0));
    opening_rows.push_back(opening_row(FUNC_WRITE, 8'h12, 3'd1, 32'h33, TBL_IMAGE, 0, 0, 0, 0));
    opening_rows.push_back(opening_row(FUNC_READ, 8'h20, 3'd4, 0, TBL_IMAGE, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_coupling(ph_first[0], ph_second[0], ph_span[0]);

    foreach (opening_rows[k]) begin
      issue_request(opening_rows[k].req, opening_rows[k].typed, opening_rows[k].want);
    end
    settle_replies(8);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        set_coupling(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 8)));
      end else begin
        set_coupling(ph_first[p], ph_second[p], ph_span[p]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        issue_request(random_request(), 1'b0, '0);
        // Now and then hold off new requests until the block has answered everything.
        if ($urandom_range(0, 79) == 0) settle_replies(0);
      end
      settle_replies(8);
    end
    burst_mode = 1'b0;
    settle_replies(16);

    $display("Ran %0d reads, %0d writes, %0d warm resets and %0d table loads, %0d of them errors.",
             n_reads, n_writes, n_warm, n_loads, n_errors);
    $display("Compared %0d responses over %0d coupled-range settings.", replies_seen,
             PHASES + 1);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
